// ----- sv/ultrasonic_range_frame_parser_core_assert.svh -----
// Assertion macros for the range frame parser core.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ULTRASONIC_RANGE_FRAME_PARSER_CORE_ASSERT_SVH
`define ULTRASONIC_RANGE_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define URFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define URFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

// Condition that must never be seen.
`define URFP_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("assertion failed");

`endif

// ----- sv/urfp_pkg.sv -----
// Shared types and constants for the range frame parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package urfp_pkg;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2,
    PH_SUM  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_VALID        = 2'd0,
    ST_CHECKSUM     = 2'd1,
    ST_INTERFERENCE = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_FRAME_HEADER      = 2'd0;
  localparam logic [1:0] CFG_INTERFERENCE_CODE = 2'd1;
  localparam logic [1:0] CFG_OUT_OF_RANGE_CODE = 2'd2;
  localparam logic [1:0] CFG_UNIT_IS_TIME      = 2'd3;

  localparam logic [7:0]  HEADER_RST       = 8'hFF;
  localparam logic [15:0] INTERFERENCE_RST = 16'hFFFE;
  localparam logic [15:0] OUT_OF_RANGE_RST = 16'hFFFD;

  // ceil(2^32 / 23): raw * 64 / 23 == (raw * RECIP_23) >> 26 for any 16-bit raw
  localparam logic [27:0] RECIP_23    = 28'd186737709;
  localparam int unsigned RECIP_SHIFT = 26;

  typedef struct packed {
    logic [7:0]  frame_header;
    logic [15:0] interference_code;
    logic [15:0] out_of_range_code;
    logic        unit_is_time;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] raw_distance;
    logic [15:0] good_frames;
    logic        fault;
  } res_t;

endpackage

// ----- sv/urfp_frame_fsm.sv -----
// Frame tracker: header hunt, byte capture, sum check and classification.
// Depends on urfp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "ultrasonic_range_frame_parser_core_assert.svh"

module urfp_frame_fsm
  import urfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output logic       is_sum_o,
  output res_t       res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  high_q, high_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] held_q, held_d;
  logic [15:0] count_q, count_d;

  logic [9:0]  sum_full;
  logic        sum_ok;
  logic [15:0] frame_raw;

  assign sum_full  = {2'b00, cfg_i.frame_header} + {2'b00, high_q} + {2'b00, low_q};
  assign sum_ok    = (byte_i == sum_full[7:0]);
  assign frame_raw = {high_q, low_q};
  assign is_sum_o  = (phase_q == PH_SUM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      high_q  <= 8'd0;
      low_q   <= 8'd0;
      held_q  <= 16'd0;
      count_q <= 16'd0;
    end else begin
      phase_q <= phase_d;
      high_q  <= high_d;
      low_q   <= low_d;
      held_q  <= held_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    high_d  = high_q;
    low_d   = low_q;
    held_d  = held_q;
    count_d = count_q;
    res_o.status       = ST_CHECKSUM;
    res_o.raw_distance = held_q;
    res_o.good_frames  = count_q;
    res_o.fault        = 1'b0;
    case (phase_q)
      PH_WAIT: begin
        // drop anything but the header while hunting
        if (fire_i && byte_i == cfg_i.frame_header) begin
          phase_d = PH_HIGH;
        end
      end
      PH_HIGH: begin
        if (fire_i) begin
          high_d  = byte_i;
          phase_d = PH_LOW;
        end
      end
      PH_LOW: begin
        if (fire_i) begin
          low_d   = byte_i;
          phase_d = PH_SUM;
        end
      end
      PH_SUM: begin
        if (sum_ok) begin
          res_o.raw_distance = frame_raw;
          res_o.good_frames  = count_q + 16'd1;
          if (frame_raw == cfg_i.interference_code) begin
            res_o.status = ST_INTERFERENCE;
            res_o.fault  = 1'b1;
          end else if (frame_raw == cfg_i.out_of_range_code) begin
            res_o.status = ST_OUT_OF_RANGE;
          end else begin
            res_o.status = ST_VALID;
          end
        end
        if (fire_i) begin
          phase_d = PH_WAIT;
          if (sum_ok) begin
            held_d  = frame_raw;
            count_d = count_q + 16'd1;
          end
        end
      end
      default: begin
        phase_d = PH_WAIT;
      end
    endcase
  end

  `URFP_ASSERT_NXT(a_sum_returns_to_hunt, fire_i && phase_q == PH_SUM, phase_q == PH_WAIT)
  `URFP_ASSERT_NXT(a_hold_when_idle, !fire_i, $stable(count_q) && $stable(held_q))
  `URFP_ASSERT_NXT(a_hunt_skips_noise,
    fire_i && phase_q == PH_WAIT && byte_i != cfg_i.frame_header, phase_q == PH_WAIT)

endmodule

// ----- sv/urfp_convert.sv -----
// Raw distance to 1/16 mm conversion, with a reciprocal multiply for time mode.
// Depends on urfp_pkg.
`timescale 1ns / 1ps

module urfp_convert
  import urfp_pkg::*;
(
  input  logic [15:0] raw_i,
  input  logic        unit_is_time_i,
  output logic [19:0] sixteenths_o
);

  logic [43:0] prod;
  logic [17:0] quot;

  // floor(raw * 64 / 23) without a divider
  assign prod = {28'd0, raw_i} * {16'd0, RECIP_23};
  assign quot = prod[RECIP_SHIFT +: 18];

  assign sixteenths_o = unit_is_time_i ? {2'b00, quot} : {raw_i, 4'b0000};

endmodule

// ----- sv/ultrasonic_range_frame_parser_core.sv -----
// Top level of the range frame parser: input word register, config registers,
// frame tracker, unit conversion and result register. Depends on urfp_pkg.
//
//   channel   signals                                      direction
//   rx        rx_valid_i / rx_ready_o / rx_byte_i          in, one serial byte
//   res       res_valid_o / res_ready_i / status_o ...     out, one per frame
//   cfg       cfg_we_i / cfg_index_i / cfg_wdata_i         in, write only
//
// One byte is processed per cycle while no sum byte stalls: it lands in the
// input register, then the tracker and converter (one 16x28 multiply) feed
// the result register, which takes a sum byte's result when that byte fires.
// Reset clears phase, captured bytes, held distance and counter, and restores
// the config defaults.
// Non-sum bytes keep flowing while a result waits; only a sum byte stalls
// when the result register is still full.
`timescale 1ns / 1ps
`include "ultrasonic_range_frame_parser_core_assert.svh"

module ultrasonic_range_frame_parser_core
  import urfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] raw_distance_o,
  output logic [19:0] distance_sixteenths_mm_o,
  output logic [15:0] good_frames_o,
  output logic        fault_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  cfg_t        cfg_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  res_t        out_res_q;
  logic [19:0] out_dist_q;

  logic        is_sum;
  logic        out_free;
  logic        fire;
  res_t        res;
  logic [19:0] conv_dist;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_header      <= HEADER_RST;
      cfg_q.interference_code <= INTERFERENCE_RST;
      cfg_q.out_of_range_code <= OUT_OF_RANGE_RST;
      cfg_q.unit_is_time      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_HEADER:      cfg_q.frame_header      <= cfg_wdata_i[7:0];
        CFG_INTERFERENCE_CODE: cfg_q.interference_code <= cfg_wdata_i;
        CFG_OUT_OF_RANGE_CODE: cfg_q.out_of_range_code <= cfg_wdata_i;
        CFG_UNIT_IS_TIME:      cfg_q.unit_is_time      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || res_ready_i;
  assign fire       = in_valid_q && (!is_sum || out_free);
  assign rx_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_ready_o && rx_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  urfp_frame_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .fire_i   (fire),
    .byte_i   (in_byte_q),
    .is_sum_o (is_sum),
    .res_o    (res)
  );

  urfp_convert u_conv (
    .raw_i          (res.raw_distance),
    .unit_is_time_i (cfg_q.unit_is_time),
    .sixteenths_o   (conv_dist)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && is_sum) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the result word until it is taken
  always_ff @(posedge clk_i) begin
    if (fire && is_sum) begin
      out_res_q  <= res;
      out_dist_q <= conv_dist;
    end
  end

  assign res_valid_o              = out_valid_q;
  assign status_o                 = out_res_q.status;
  assign raw_distance_o           = out_res_q.raw_distance;
  assign distance_sixteenths_mm_o = out_dist_q;
  assign good_frames_o            = out_res_q.good_frames;
  assign fault_o                  = out_res_q.fault;

  `URFP_ASSERT_IMP(a_fault_matches_status, out_valid_q,
    out_res_q.fault == (out_res_q.status == ST_INTERFERENCE))
  `URFP_ASSERT_NEVER(a_no_result_overwrite, fire && is_sum && out_valid_q && !res_ready_i)
  `URFP_ASSERT_NXT(a_input_word_held, in_valid_q && !fire, in_valid_q && $stable(in_byte_q))

endmodule
